// ===== sv/skr_pkg.sv =====
`timescale 1ns / 1ps
package skr_pkg;

    localparam int STORE_DEPTH_DEF = 16;
    localparam int NAME_BYTES_DEF  = 20;
    localparam int NUM_STORES      = 3;
    localparam int MAX_NAME_BYTES  = 20;
    localparam int NAME_W          = 8 * MAX_NAME_BYTES;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_SEARCH = 3'd2,
        OP_LIST   = 3'd3,
        OP_TOTAL  = 3'd4,
        OP_MOVE   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_CAT   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_USE,
        S_ADD,
        S_INS_RD,
        S_INS_USE,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [31:0]       code;
        logic [31:0]       qty;
        logic [31:0]       price;
    } rec_t;

    typedef struct packed {
        status_t      status;
        logic [1:0]   found;
        rec_t         rec;
        logic [63:0]  total;
        logic         last;
    } res_t;

    // Bytes past the name length, and all bytes after the first zero, read as zero.
    function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] n,
                                                     input int nb);
        logic [NAME_W-1:0] r;
        logic              ended;
        logic [7:0]        b;
        r     = '0;
        ended = 1'b0;
        for (int k = 0; k < MAX_NAME_BYTES; k++)
        begin
            b = n[NAME_W-1-8*k -: 8];
            if (k >= nb || ended)
            begin
                b = 8'd0;
            end
            if (b == 8'd0)
            begin
                ended = 1'b1;
            end
            r[NAME_W-1-8*k -: 8] = b;
        end
        return r;
    endfunction

endpackage

// ===== sv/skr_if.sv =====
`timescale 1ns / 1ps
interface skr_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [1:0]         category;
    logic [1:0]         target_category;
    logic [63:0]        name_0;
    logic [63:0]        name_1;
    logic [31:0]        name_2;
    logic signed [31:0] code;
    logic signed [31:0] quantity;
    logic signed [31:0] price;

    modport source (output valid, kind, category, target_category, name_0, name_1, name_2,
                    code, quantity, price, input ready);
    modport sink (input valid, kind, category, target_category, name_0, name_1, name_2,
                  code, quantity, price, output ready);
endinterface

interface skr_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [1:0]         found_category;
    logic [63:0]        out_name_0;
    logic [63:0]        out_name_1;
    logic [31:0]        out_name_2;
    logic signed [31:0] out_code;
    logic signed [31:0] out_quantity;
    logic signed [31:0] out_price;
    logic signed [63:0] total_value;
    logic               last;

    modport source (output valid, status, found_category, out_name_0, out_name_1, out_name_2,
                    out_code, out_quantity, out_price, total_value, last, input ready);
    modport sink (input valid, status, found_category, out_name_0, out_name_1, out_name_2,
                  out_code, out_quantity, out_price, total_value, last, output ready);
endinterface

// ===== sv/sorted_keyed_record_store.sv =====
`timescale 1ns / 1ps
// Three sorted record stores sharing one synchronous record memory.
// req carries one operation per transaction (insert, delete, search, list,
// total, move); rsp returns its results, the final one marked by last.
// req is taken only while the sequencer is idle; one operation at a time.
// Each scan step reads a record from memory, then uses it; total adds a step,
// as the multiply has its own register. Each store boundary takes a step of
// its own; a scan ends with a wrap-up step and, but for a list that has sent
// records, a step that loads the result. Insert walks down from the top of
// its store, reading and then writing each record that it shifts. Move runs
// a counting scan, then a compacting scan where every match triggers an
// insert walk in the target store.
// A result sits in the output register until taken; while rsp stalls the
// sequencer holds, and the final result does not block the next req.
// Reset empties all stores (fill counts to zero); memory contents are not
// cleared, and no clearing pass is needed.
module sorted_keyed_record_store #(
    parameter int STORE_DEPTH = skr_pkg::STORE_DEPTH_DEF,
    parameter int NAME_BYTES  = skr_pkg::NAME_BYTES_DEF
) (
    input logic       clk,
    input logic       rst_n,
    skr_req_if.sink   req,
    skr_rsp_if.source rsp
);

    localparam int ENTRIES = skr_pkg::NUM_STORES * STORE_DEPTH;
    localparam int AW      = $clog2(ENTRIES);

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    skr_pkg::rec_t wr_data;
    skr_pkg::rec_t rd_data;

    skr_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .NAME_BYTES  (NAME_BYTES),
        .AW          (AW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    skr_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // a valid operation makes the sequencer busy in the cycle after it is taken
    a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.kind <= 3'd5 |=> !req.ready)
        else $error("req ready right after a valid operation");

    // an operation is not finished while a non-final result is out
    a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.last |-> !req.ready)
        else $error("req ready while a result burst is open");

    // error and not-found results carry no record
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != skr_pkg::ST_OK |->
            rsp.found_category == 2'd0 && rsp.out_name_0 == 64'd0 &&
            rsp.out_code == 32'sd0 && rsp.total_value == 64'sd0 && rsp.last)
        else $error("error result carries data");

    // only the single total result carries a sum
    a_total_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.total_value != 64'sd0 |->
            rsp.last && rsp.found_category == 2'd0 && rsp.out_name_0 == 64'd0)
        else $error("sum on a non-total result");

endmodule

// ===== sv/skr_mem.sv =====
`timescale 1ns / 1ps
module skr_mem #(
    parameter int ENTRIES = 48,
    parameter int AW      = 6
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  skr_pkg::rec_t     wr_data,
    output skr_pkg::rec_t     rd_data
);

    skr_pkg::rec_t mem_array [0:ENTRIES-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_array[rd_addr];
        end
    end

endmodule

// ===== sv/skr_ctrl.sv =====
`timescale 1ns / 1ps
module skr_ctrl #(
    parameter int STORE_DEPTH = skr_pkg::STORE_DEPTH_DEF,
    parameter int NAME_BYTES  = skr_pkg::NAME_BYTES_DEF,
    parameter int AW          = $clog2(skr_pkg::NUM_STORES * STORE_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    skr_req_if.sink       req,
    skr_rsp_if.source     rsp,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output skr_pkg::rec_t wr_data,
    input  skr_pkg::rec_t rd_data
);

    localparam int IW = $clog2(STORE_DEPTH + 1);
    localparam int CW = $clog2(2 * STORE_DEPTH + 1);
    localparam logic [1:0] STORE_NONE = 2'd3;
    localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

    skr_pkg::state_t   state_reg, state_next;
    skr_pkg::op_t      op_reg, op_next;
    logic [1:0]        cat_reg, cat_next;
    logic [1:0]        tgt_reg, tgt_next;
    logic [skr_pkg::NAME_W-1:0] name_reg, name_next;
    skr_pkg::rec_t     ins_rec_reg, ins_rec_next;
    logic [1:0]        store_reg, store_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     wptr_reg, wptr_next;
    logic [1:0]        ins_store_reg, ins_store_next;
    logic [IW-1:0]     ins_idx_reg, ins_idx_next;
    logic [IW-1:0]     fill_reg [0:2];
    logic [IW-1:0]     fill_next [0:2];
    logic              any_reg, any_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              phase_reg, phase_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg, prod_next;
    skr_pkg::res_t     pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    skr_pkg::res_t     out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    skr_pkg::op_t      kind_in;
    logic [skr_pkg::NAME_W-1:0] name_in;
    logic              accept;
    logic              can_emit;
    logic              in_bad;
    logic              in_full;
    logic [IW-1:0]     cur_fill;
    logic [IW-1:0]     tgt_fill;
    logic [1:0]        tgt_store;
    logic              rd_done;
    logic              store_end;
    logic              move_ok;
    logic              d_match;
    logic              ins_place;
    logic              search_stall;
    logic              list_stall;
    logic signed [63:0] sum;
    logic signed [63:0] sat_sum;

    function automatic logic [AW-1:0] slot(input logic [1:0] s, input logic [IW-1:0] i);
        return AW'(32'(s) * STORE_DEPTH + 32'(i));
    endfunction

    function automatic logic [1:0] first_store(input skr_pkg::op_t op, input logic [1:0] c,
                                               input logic [1:0] t);
        if (op == skr_pkg::OP_LIST)
        begin
            return c - 2'd1;
        end
        if (op == skr_pkg::OP_MOVE && t == 2'd1)
        begin
            return 2'd1;
        end
        return 2'd0;
    endfunction

    function automatic logic [1:0] next_store(input skr_pkg::op_t op, input logic [1:0] s,
                                              input logic [1:0] t);
        logic [1:0] n;
        n = s + 2'd1;
        if (op == skr_pkg::OP_LIST)
        begin
            n = STORE_NONE;
        end
        else if (op == skr_pkg::OP_MOVE && n != STORE_NONE && n == t - 2'd1)
        begin
            n = n + 2'd1;
        end
        return n;
    endfunction

    function automatic skr_pkg::res_t bare(input skr_pkg::status_t st, input logic [1:0] f);
        skr_pkg::res_t r;
        r        = '0;
        r.status = st;
        r.found  = f;
        r.last   = 1'b1;
        return r;
    endfunction

    assign kind_in   = skr_pkg::op_t'(req.kind);
    assign name_in   = skr_pkg::normalize({req.name_0, req.name_1, req.name_2}, NAME_BYTES);
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == skr_pkg::S_IDLE);
    assign can_emit  = !out_valid_reg || rsp.ready;

    assign in_bad  = ((kind_in == skr_pkg::OP_INSERT || kind_in == skr_pkg::OP_LIST)
                      && req.category == 2'd0)
                     || (kind_in == skr_pkg::OP_MOVE && req.target_category == 2'd0);
    assign in_full = (req.category != 2'd0)
                     && (32'(fill_reg[req.category - 2'd1]) >= STORE_DEPTH);

    assign tgt_store = tgt_reg - 2'd1;
    assign cur_fill  = (store_reg == STORE_NONE) ? '0 : fill_reg[store_reg];
    assign tgt_fill  = (tgt_store == STORE_NONE) ? '0 : fill_reg[tgt_store];
    assign rd_done   = (store_reg == STORE_NONE);
    assign store_end = !rd_done && (idx_reg >= cur_fill);
    assign move_ok   = (cnt_reg != '0) && (32'(tgt_fill) + 32'(cnt_reg) <= STORE_DEPTH);

    assign d_match   = (rd_data.name == name_reg);
    assign ins_place = (rd_data.name < ins_rec_reg.name);
    assign search_stall = (op_reg == skr_pkg::OP_SEARCH) && d_match && pend_valid_reg
                          && !can_emit;
    assign list_stall   = (op_reg == skr_pkg::OP_LIST) && !can_emit;

    assign sum     = acc_reg + prod_reg;
    assign sat_sum = (acc_reg[63] == prod_reg[63] && sum[63] != acc_reg[63])
                     ? (prod_reg[63] ? ACC_MIN : ACC_MAX) : sum;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_in)
                        skr_pkg::OP_INSERT:
                            state_next = (in_bad || in_full) ? skr_pkg::S_FIN : skr_pkg::S_INS_RD;
                        skr_pkg::OP_LIST, skr_pkg::OP_MOVE:
                            state_next = in_bad ? skr_pkg::S_FIN : skr_pkg::S_RD;
                        skr_pkg::OP_DELETE, skr_pkg::OP_SEARCH, skr_pkg::OP_TOTAL:
                            state_next = skr_pkg::S_RD;
                        default:
                            state_next = skr_pkg::S_IDLE;
                    endcase
                end
            end
            skr_pkg::S_RD:
            begin
                if (rd_done)
                begin
                    case (op_reg)
                        skr_pkg::OP_LIST:
                            state_next = any_reg ? skr_pkg::S_IDLE : skr_pkg::S_FIN;
                        skr_pkg::OP_MOVE:
                            state_next = (!phase_reg && move_ok) ? skr_pkg::S_RD : skr_pkg::S_FIN;
                        default:
                            state_next = skr_pkg::S_FIN;
                    endcase
                end
                else if (!store_end)
                begin
                    state_next = skr_pkg::S_USE;
                end
            end
            skr_pkg::S_USE:
            begin
                case (op_reg)
                    skr_pkg::OP_DELETE:
                        state_next = skr_pkg::S_RD;
                    skr_pkg::OP_SEARCH:
                        state_next = search_stall ? skr_pkg::S_USE : skr_pkg::S_RD;
                    skr_pkg::OP_LIST:
                        state_next = list_stall ? skr_pkg::S_USE : skr_pkg::S_RD;
                    skr_pkg::OP_TOTAL:
                        state_next = skr_pkg::S_ADD;
                    skr_pkg::OP_MOVE:
                        state_next = (phase_reg && d_match) ? skr_pkg::S_INS_RD : skr_pkg::S_RD;
                    default:
                        state_next = skr_pkg::S_IDLE;
                endcase
            end
            skr_pkg::S_ADD:
                state_next = skr_pkg::S_RD;
            skr_pkg::S_INS_RD:
            begin
                if (ins_idx_reg == '0)
                begin
                    state_next = (op_reg == skr_pkg::OP_INSERT) ? skr_pkg::S_FIN : skr_pkg::S_RD;
                end
                else
                begin
                    state_next = skr_pkg::S_INS_USE;
                end
            end
            skr_pkg::S_INS_USE:
            begin
                if (ins_place)
                begin
                    state_next = (op_reg == skr_pkg::OP_INSERT) ? skr_pkg::S_FIN : skr_pkg::S_RD;
                end
                else
                begin
                    state_next = skr_pkg::S_INS_RD;
                end
            end
            skr_pkg::S_FIN:
                state_next = can_emit ? skr_pkg::S_IDLE : skr_pkg::S_FIN;
            default:
                state_next = skr_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        op_next         = op_reg;
        cat_next        = cat_reg;
        tgt_next        = tgt_reg;
        name_next       = name_reg;
        ins_rec_next    = ins_rec_reg;
        store_next      = store_reg;
        idx_next        = idx_reg;
        wptr_next       = wptr_reg;
        ins_store_next  = ins_store_reg;
        ins_idx_next    = ins_idx_reg;
        fill_next       = fill_reg;
        any_next        = any_reg;
        cnt_next        = cnt_reg;
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data;

        unique case (state_reg)
            skr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = kind_in;
                    cat_next        = req.category;
                    tgt_next        = req.target_category;
                    name_next       = name_in;
                    ins_rec_next    = {name_in, req.code, req.quantity, req.price};
                    store_next      = first_store(kind_in, req.category, req.target_category);
                    idx_next        = '0;
                    wptr_next       = '0;
                    any_next        = 1'b0;
                    cnt_next        = '0;
                    phase_next      = 1'b0;
                    acc_next        = '0;
                    pend_valid_next = 1'b0;
                    ins_store_next  = req.category - 2'd1;
                    ins_idx_next    = fill_reg[req.category - 2'd1];
                    if (in_bad)
                    begin
                        pend_next = bare(skr_pkg::ST_BAD_CAT, 2'd0);
                    end
                    else if (kind_in == skr_pkg::OP_INSERT && in_full)
                    begin
                        pend_next = bare(skr_pkg::ST_FULL, 2'd0);
                    end
                end
            end
            skr_pkg::S_RD:
            begin
                if (rd_done)
                begin
                    case (op_reg)
                        skr_pkg::OP_DELETE:
                            pend_next = bare(any_reg ? skr_pkg::ST_OK : skr_pkg::ST_NOT_FOUND,
                                             2'd0);
                        skr_pkg::OP_SEARCH:
                        begin
                            if (pend_valid_reg)
                            begin
                                pend_next.last = 1'b1;
                            end
                            else
                            begin
                                pend_next = bare(skr_pkg::ST_NOT_FOUND, 2'd0);
                            end
                        end
                        skr_pkg::OP_TOTAL:
                        begin
                            pend_next       = bare(skr_pkg::ST_OK, 2'd0);
                            pend_next.total = acc_reg;
                        end
                        skr_pkg::OP_MOVE:
                        begin
                            if (phase_reg)
                            begin
                                pend_next = bare(skr_pkg::ST_OK, tgt_reg);
                            end
                            else if (cnt_reg == '0)
                            begin
                                pend_next = bare(skr_pkg::ST_NOT_FOUND, 2'd0);
                            end
                            else if (!move_ok)
                            begin
                                pend_next = bare(skr_pkg::ST_FULL, 2'd0);
                            end
                            else
                            begin
                                phase_next = 1'b1;
                                store_next = first_store(op_reg, cat_reg, tgt_reg);
                                idx_next   = '0;
                                wptr_next  = '0;
                            end
                        end
                        default:
                            pend_next = bare(skr_pkg::ST_NOT_FOUND, 2'd0);
                    endcase
                end
                else if (store_end)
                begin
                    // compacting passes shrink the store to what was kept
                    if (op_reg == skr_pkg::OP_DELETE || (op_reg == skr_pkg::OP_MOVE && phase_reg))
                    begin
                        fill_next[store_reg] = wptr_reg;
                    end
                    store_next = next_store(op_reg, store_reg, tgt_reg);
                    idx_next   = '0;
                    wptr_next  = '0;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = slot(store_reg, idx_reg);
                end
            end
            skr_pkg::S_USE:
            begin
                case (op_reg)
                    skr_pkg::OP_DELETE:
                    begin
                        if (d_match)
                        begin
                            any_next = 1'b1;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = slot(store_reg, wptr_reg);
                            wptr_next = wptr_reg + 1'b1;
                        end
                        idx_next = idx_reg + 1'b1;
                    end
                    skr_pkg::OP_SEARCH:
                    begin
                        if (!search_stall)
                        begin
                            if (d_match)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_next       = pend_reg;
                                    out_valid_next = 1'b1;
                                end
                                pend_next       = bare(skr_pkg::ST_OK, store_reg + 2'd1);
                                pend_next.rec   = rd_data;
                                pend_next.last  = 1'b0;
                                pend_valid_next = 1'b1;
                            end
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    skr_pkg::OP_LIST:
                    begin
                        if (!list_stall)
                        begin
                            out_next       = bare(skr_pkg::ST_OK, cat_reg);
                            out_next.rec   = rd_data;
                            out_next.last  = (idx_reg == cur_fill - 1'b1);
                            out_valid_next = 1'b1;
                            any_next       = 1'b1;
                            idx_next       = idx_reg + 1'b1;
                        end
                    end
                    skr_pkg::OP_TOTAL:
                        prod_next = $signed(rd_data.qty) * $signed(rd_data.price);
                    skr_pkg::OP_MOVE:
                    begin
                        if (!phase_reg)
                        begin
                            if (d_match)
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        else if (d_match)
                        begin
                            ins_rec_next   = rd_data;
                            ins_store_next = tgt_store;
                            ins_idx_next   = tgt_fill;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = slot(store_reg, wptr_reg);
                            wptr_next = wptr_reg + 1'b1;
                        end
                        idx_next = idx_reg + 1'b1;
                    end
                    default:
                        idx_next = idx_reg;
                endcase
            end
            skr_pkg::S_ADD:
            begin
                acc_next = sat_sum;
                idx_next = idx_reg + 1'b1;
            end
            skr_pkg::S_INS_RD:
            begin
                if (ins_idx_reg == '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = slot(ins_store_reg, '0);
                    wr_data = ins_rec_reg;
                    fill_next[ins_store_reg] = fill_reg[ins_store_reg] + 1'b1;
                    pend_next     = bare(skr_pkg::ST_OK, cat_reg);
                    pend_next.rec = ins_rec_reg;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = slot(ins_store_reg, ins_idx_reg - 1'b1);
                end
            end
            skr_pkg::S_INS_USE:
            begin
                // walk down from the top, shifting larger-or-equal names up by one
                wr_en   = 1'b1;
                wr_addr = slot(ins_store_reg, ins_idx_reg);
                if (ins_place)
                begin
                    wr_data = ins_rec_reg;
                    fill_next[ins_store_reg] = fill_reg[ins_store_reg] + 1'b1;
                    pend_next     = bare(skr_pkg::ST_OK, cat_reg);
                    pend_next.rec = ins_rec_reg;
                end
                else
                begin
                    ins_idx_next = ins_idx_reg - 1'b1;
                end
            end
            skr_pkg::S_FIN:
            begin
                if (can_emit)
                begin
                    out_next        = pend_reg;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
                out_next = out_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= skr_pkg::S_IDLE;
            fill_reg       <= '{default: '0};
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        cat_reg       <= cat_next;
        tgt_reg       <= tgt_next;
        name_reg      <= name_next;
        ins_rec_reg   <= ins_rec_next;
        store_reg     <= store_next;
        idx_reg       <= idx_next;
        wptr_reg      <= wptr_next;
        ins_store_reg <= ins_store_next;
        ins_idx_reg   <= ins_idx_next;
        any_reg       <= any_next;
        cnt_reg       <= cnt_next;
        phase_reg     <= phase_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.found_category = out_reg.found;
    assign rsp.out_name_0     = out_reg.rec.name[159:96];
    assign rsp.out_name_1     = out_reg.rec.name[95:32];
    assign rsp.out_name_2     = out_reg.rec.name[31:0];
    assign rsp.out_code       = out_reg.rec.code;
    assign rsp.out_quantity   = out_reg.rec.qty;
    assign rsp.out_price      = out_reg.rec.price;
    assign rsp.total_value    = out_reg.total;
    assign rsp.last           = out_reg.last;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int DEPTH = 16;
    localparam int NB    = 20;

    typedef struct {
        logic [2:0]  kind;
        logic [1:0]  category;
        logic [1:0]  target_category;
        logic [159:0] name;
        logic [31:0] code;
        logic [31:0] quantity;
        logic [31:0] price;
    } op_item_t;

    typedef struct {
        logic [1:0]   status;
        logic [1:0]   found;
        logic [159:0] name;
        logic [31:0]  code;
        logic [31:0]  quantity;
        logic [31:0]  price;
        logic [63:0]  total;
        logic         last;
    } result_t;

    logic clk;
    logic rst_n;

    skr_req_if req ();
    skr_rsp_if rsp ();

    sorted_keyed_record_store #(.STORE_DEPTH(DEPTH), .NAME_BYTES(NB)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // shadow of the three stores
    logic [159:0] sh_name [3][DEPTH];
    logic [31:0]  sh_code [3][DEPTH];
    logic [31:0]  sh_qty  [3][DEPTH];
    logic [31:0]  sh_price[3][DEPTH];
    int           sh_fill [3];

    op_item_t pending_ops[$];
    result_t  expected_results[$];
    int       error_count;
    int       hold_off_cycles;
    bit       sender_wait_drain;
    bit       quiet_mode;
    logic     req_taken_prev;

    logic [159:0] name_pool[8];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("sorted_keyed_record_store: mismatch");
        $finish;
    end

    function automatic logic [159:0] norm_name(logic [159:0] n);
        logic [159:0] r;
        logic         ended;
        logic [7:0]   b;
        r = '0;
        ended = 1'b0;
        for (int k = 0; k < 20; k++)
        begin
            b = n[159-8*k -: 8];
            if (k >= NB || ended)
                b = 8'd0;
            if (b == 8'd0)
                ended = 1'b1;
            r[159-8*k -: 8] = b;
        end
        return r;
    endfunction

    function automatic result_t blank_result(logic [1:0] st, logic [1:0] fc);
        result_t r;
        r = '{default: '0};
        r.status = st;
        r.found = fc;
        return r;
    endfunction

    function automatic result_t slot_result(int s);
        result_t r;
        r = blank_result(skr_pkg::ST_OK, 2'(s + 1));
        return r;
    endfunction

    function automatic bit place_record(int s, logic [159:0] n, logic [31:0] c,
                                        logic [31:0] q, logic [31:0] p);
        int pos;
        if (sh_fill[s] >= DEPTH)
            return 1'b0;
        pos = 0;
        while (pos < sh_fill[s] && sh_name[s][pos] < n)
            pos++;
        for (int i = sh_fill[s]; i > pos; i--)
        begin
            sh_name[s][i] = sh_name[s][i-1];
            sh_code[s][i] = sh_code[s][i-1];
            sh_qty[s][i] = sh_qty[s][i-1];
            sh_price[s][i] = sh_price[s][i-1];
        end
        sh_name[s][pos] = n;
        sh_code[s][pos] = c;
        sh_qty[s][pos] = q;
        sh_price[s][pos] = p;
        sh_fill[s]++;
        return 1'b1;
    endfunction

    function automatic void drop_record(int s, int pos);
        for (int i = pos; i + 1 < sh_fill[s]; i++)
        begin
            sh_name[s][i] = sh_name[s][i+1];
            sh_code[s][i] = sh_code[s][i+1];
            sh_qty[s][i] = sh_qty[s][i+1];
            sh_price[s][i] = sh_price[s][i+1];
        end
        sh_fill[s]--;
    endfunction

    function automatic void push_record(int s, int i);
        result_t r;
        r = slot_result(s);
        r.name = sh_name[s][i];
        r.code = sh_code[s][i];
        r.quantity = sh_qty[s][i];
        r.price = sh_price[s][i];
        expected_results.push_back(r);
    endfunction

    // appends the results that one operation causes and updates the shadow
    function automatic void predict_op(op_item_t op);
        logic [159:0]       n;
        result_t            r;
        int                 first;
        int                 t;
        int                 cnt;
        int                 i;
        bit                 any;
        logic signed [63:0] acc;
        logic signed [63:0] prod;
        logic signed [64:0] wide;
        logic [31:0]        rc, rq, rp;
        n = norm_name(op.name);
        first = expected_results.size();
        case (op.kind)
            skr_pkg::OP_INSERT:
            begin
                if (op.category == 0)
                    expected_results.push_back(blank_result(skr_pkg::ST_BAD_CAT, 0));
                else if (!place_record(op.category - 1, n, op.code, op.quantity, op.price))
                    expected_results.push_back(blank_result(skr_pkg::ST_FULL, 0));
                else
                begin
                    r = blank_result(skr_pkg::ST_OK, op.category);
                    r.name = n;
                    r.code = op.code;
                    r.quantity = op.quantity;
                    r.price = op.price;
                    expected_results.push_back(r);
                end
            end
            skr_pkg::OP_DELETE:
            begin
                any = 1'b0;
                for (int s = 0; s < 3; s++)
                begin
                    i = 0;
                    while (i < sh_fill[s])
                    begin
                        if (sh_name[s][i] == n)
                        begin
                            drop_record(s, i);
                            any = 1'b1;
                        end
                        else
                            i++;
                    end
                end
                expected_results.push_back(blank_result(any ? skr_pkg::ST_OK
                                                            : skr_pkg::ST_NOT_FOUND, 0));
            end
            skr_pkg::OP_SEARCH:
            begin
                for (int s = 0; s < 3; s++)
                    for (int k = 0; k < sh_fill[s]; k++)
                        if (sh_name[s][k] == n)
                            push_record(s, k);
                if (expected_results.size() == first)
                    expected_results.push_back(blank_result(skr_pkg::ST_NOT_FOUND, 0));
            end
            skr_pkg::OP_LIST:
            begin
                if (op.category == 0)
                    expected_results.push_back(blank_result(skr_pkg::ST_BAD_CAT, 0));
                else
                begin
                    for (int k = 0; k < sh_fill[op.category - 1]; k++)
                        push_record(op.category - 1, k);
                    if (expected_results.size() == first)
                        expected_results.push_back(blank_result(skr_pkg::ST_NOT_FOUND, 0));
                end
            end
            skr_pkg::OP_TOTAL:
            begin
                acc = 0;
                for (int s = 0; s < 3; s++)
                    for (int k = 0; k < sh_fill[s]; k++)
                    begin
                        prod = $signed(sh_qty[s][k]) * $signed(sh_price[s][k]);
                        wide = 65'(acc) + 65'(prod);
                        if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF)
                            acc = 64'sh7FFF_FFFF_FFFF_FFFF;
                        else if (wide < -65'sh0_8000_0000_0000_0000)
                            acc = 64'sh8000_0000_0000_0000;
                        else
                            acc = wide[63:0];
                    end
                r = blank_result(skr_pkg::ST_OK, 0);
                r.total = acc;
                expected_results.push_back(r);
            end
            skr_pkg::OP_MOVE:
            begin
                if (op.target_category == 0)
                    expected_results.push_back(blank_result(skr_pkg::ST_BAD_CAT, 0));
                else
                begin
                    t = op.target_category - 1;
                    cnt = 0;
                    for (int s = 0; s < 3; s++)
                        if (s != t)
                            for (int k = 0; k < sh_fill[s]; k++)
                                if (sh_name[s][k] == n)
                                    cnt++;
                    if (cnt == 0)
                        expected_results.push_back(blank_result(skr_pkg::ST_NOT_FOUND, 0));
                    else if (sh_fill[t] + cnt > DEPTH)
                        expected_results.push_back(blank_result(skr_pkg::ST_FULL, 0));
                    else
                    begin
                        for (int s = 0; s < 3; s++)
                        begin
                            if (s == t)
                                continue;
                            i = 0;
                            while (i < sh_fill[s])
                            begin
                                if (sh_name[s][i] == n)
                                begin
                                    rc = sh_code[s][i];
                                    rq = sh_qty[s][i];
                                    rp = sh_price[s][i];
                                    drop_record(s, i);
                                    void'(place_record(t, n, rc, rq, rp));
                                end
                                else
                                    i++;
                            end
                        end
                        expected_results.push_back(blank_result(skr_pkg::ST_OK,
                                                                op.target_category));
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (expected_results.size() > first)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [159:0] got, logic [159:0] want);
        error_count++;
        $display("t=%0t %s got %h want %h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
        req_taken_prev <= req.valid && req.ready;

    // driver
    always @(negedge clk)
    begin
        op_item_t op;
        if (rst_n && (!req.valid || req_taken_prev))
        begin
            if (sender_wait_drain && expected_results.size() != 0)
                req.valid <= 1'b0;
            else if (pending_ops.size() != 0 && (quiet_mode || $urandom_range(99) >= 36))
            begin
                op = pending_ops.pop_front();
                if (op.kind == 3'd7 && op.category == 2'd3 && op.code == 32'hD0A1)
                begin
                    // drain marker: hold off until every expected result is in
                    sender_wait_drain <= 1'b1;
                    req.valid <= 1'b0;
                end
                else
                begin
                    sender_wait_drain <= 1'b0;
                    req.valid <= 1'b1;
                    req.kind <= op.kind;
                    req.category <= op.category;
                    req.target_category <= op.target_category;
                    req.name_0 <= op.name[159:96];
                    req.name_1 <= op.name[95:32];
                    req.name_2 <= op.name[31:0];
                    req.code <= op.code;
                    req.quantity <= op.quantity;
                    req.price <= op.price;
                end
            end
            else
                req.valid <= 1'b0;
        end
    end

    // predictor runs on the accepted transaction
    always @(posedge clk)
    begin
        op_item_t op;
        if (rst_n && req.valid && req.ready)
        begin
            op.kind = req.kind;
            op.category = req.category;
            op.target_category = req.target_category;
            op.name = {req.name_0, req.name_1, req.name_2};
            op.code = req.code;
            op.quantity = req.quantity;
            op.price = req.price;
            predict_op(op);
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= quiet_mode || ($urandom_range(99) >= 36);
    end

    // monitor
    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", {rsp.out_name_0, rsp.out_name_1,
                                rsp.out_name_2}, '0);
            else
            begin
                w = expected_results.pop_front();
                if (rsp.status !== w.status)
                    report_mismatch("status", rsp.status, w.status);
                if (rsp.found_category !== w.found)
                    report_mismatch("found_category", rsp.found_category, w.found);
                if ({rsp.out_name_0, rsp.out_name_1, rsp.out_name_2} !== w.name)
                    report_mismatch("name", {rsp.out_name_0, rsp.out_name_1,
                                    rsp.out_name_2}, w.name);
                if (rsp.out_code !== w.code)
                    report_mismatch("code", rsp.out_code, w.code);
                if (rsp.out_quantity !== w.quantity)
                    report_mismatch("quantity", rsp.out_quantity, w.quantity);
                if (rsp.out_price !== w.price)
                    report_mismatch("price", rsp.out_price, w.price);
                if (rsp.total_value !== w.total)
                    report_mismatch("total_value", rsp.total_value, w.total);
                if (rsp.last !== w.last)
                    report_mismatch("last", rsp.last, w.last);
            end
        end
    end

    function automatic logic [159:0] random_name();
        logic [159:0] n;
        n = {$urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(3) == 0)
            n[159 - 8 * $urandom_range(19) -: 8] = 8'd0;
        return n;
    endfunction

    function automatic op_item_t make_op(logic [2:0] k, logic [1:0] c, logic [1:0] t,
                                         logic [159:0] n);
        op_item_t op;
        op.kind = k;
        op.category = c;
        op.target_category = t;
        op.name = n;
        op.code = $urandom;
        op.quantity = $urandom;
        op.price = $urandom;
        return op;
    endfunction

    function automatic op_item_t drain_marker();
        op_item_t op;
        op = make_op(3'd7, 2'd3, 2'd0, '0);
        op.code = 32'hD0A1;
        return op;
    endfunction

    function automatic op_item_t random_op();
        int       r;
        logic [159:0] n;
        r = $urandom_range(99);
        n = ($urandom_range(9) == 0) ? random_name() : name_pool[$urandom_range(7)];
        if (r < 40)
            return make_op(skr_pkg::OP_INSERT,
                           $urandom_range(9) == 0 ? 0 : $urandom_range(1, 3), 0, n);
        if (r < 52)
            return make_op(skr_pkg::OP_DELETE, $urandom_range(3), $urandom_range(3), n);
        if (r < 67)
            return make_op(skr_pkg::OP_SEARCH, $urandom_range(3), $urandom_range(3), n);
        if (r < 77)
            return make_op(skr_pkg::OP_LIST, $urandom_range(3), $urandom_range(3), n);
        if (r < 85)
            return make_op(skr_pkg::OP_TOTAL, $urandom_range(3), $urandom_range(3), n);
        if (r < 97)
            return make_op(skr_pkg::OP_MOVE, $urandom_range(3), $urandom_range(3), n);
        return make_op($urandom_range(6, 7), $urandom_range(2), $urandom_range(3), n);
    endfunction

    initial
    begin
        op_item_t op;
        int       guard;
        error_count = 0;
        hold_off_cycles = 0;
        sender_wait_drain = 1'b0;
        quiet_mode = 1'b0;
        req_taken_prev = 1'b0;
        for (int s = 0; s < 3; s++)
            sh_fill[s] = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.kind = '0;
        req.category = '0;
        req.target_category = '0;
        req.name_0 = '0;
        req.name_1 = '0;
        req.name_2 = '0;
        req.code = '0;
        req.quantity = '0;
        req.price = '0;
        rsp.ready = 1'b0;

        for (int k = 0; k < 8; k++)
            name_pool[k] = {8'h41 + 8'(k % 4), 8'h61 + 8'(k), 144'h0};
        name_pool[6] = {160{1'b1}};
        name_pool[7] = '0;

        // directed part
        pending_ops.push_back(make_op(skr_pkg::OP_LIST, 1, 0, '0));
        pending_ops.push_back(make_op(skr_pkg::OP_SEARCH, 0, 0, name_pool[0]));
        pending_ops.push_back(make_op(skr_pkg::OP_DELETE, 0, 0, name_pool[0]));
        pending_ops.push_back(make_op(skr_pkg::OP_TOTAL, 0, 0, '0));
        pending_ops.push_back(make_op(skr_pkg::OP_INSERT, 0, 0, name_pool[0]));
        op = make_op(skr_pkg::OP_INSERT, 1, 0, {160{1'b1}});
        op.quantity = 32'h7FFF_FFFF;
        op.price = 32'h7FFF_FFFF;
        pending_ops.push_back(op);
        op = make_op(skr_pkg::OP_INSERT, 1, 0, {8'h41, 8'h00, 144'hFFFF_FFFF});
        op.quantity = 32'h8000_0000;
        op.price = 32'h8000_0000;
        pending_ops.push_back(op);
        pending_ops.push_back(make_op(skr_pkg::OP_INSERT, 2, 0, name_pool[0]));
        pending_ops.push_back(make_op(skr_pkg::OP_INSERT, 3, 0, name_pool[0]));
        pending_ops.push_back(make_op(skr_pkg::OP_INSERT, 3, 0, '0));
        pending_ops.push_back(make_op(skr_pkg::OP_SEARCH, 0, 0, name_pool[0]));
        pending_ops.push_back(make_op(skr_pkg::OP_LIST, 0, 0, '0));
        pending_ops.push_back(make_op(skr_pkg::OP_LIST, 1, 0, '0));
        pending_ops.push_back(make_op(skr_pkg::OP_TOTAL, 0, 0, '0));
        pending_ops.push_back(make_op(skr_pkg::OP_MOVE, 0, 0, name_pool[0]));
        pending_ops.push_back(make_op(skr_pkg::OP_MOVE, 0, 1, name_pool[0]));
        pending_ops.push_back(make_op(skr_pkg::OP_MOVE, 0, 2, name_pool[5]));
        pending_ops.push_back(make_op(skr_pkg::OP_LIST, 1, 0, '0));
        pending_ops.push_back(make_op(6, 1, 1, name_pool[1]));
        pending_ops.push_back(make_op(7, 2, 2, name_pool[1]));
        // fill store 2 to overflow it
        for (int k = 0; k < 17; k++)
            pending_ops.push_back(make_op(skr_pkg::OP_INSERT, 2, 0, name_pool[k % 3]));
        pending_ops.push_back(make_op(skr_pkg::OP_MOVE, 0, 2, name_pool[0]));
        pending_ops.push_back(make_op(skr_pkg::OP_TOTAL, 0, 0, '0));
        pending_ops.push_back(make_op(skr_pkg::OP_LIST, 2, 0, '0));
        pending_ops.push_back(drain_marker());
        pending_ops.push_back(make_op(skr_pkg::OP_DELETE, 0, 0, name_pool[0]));

        for (int k = 0; k < 220; k++)
        begin
            pending_ops.push_back(random_op());
            if (k == 110)
                pending_ops.push_back(drain_marker());
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // long receiver hold-off while the sender keeps offering
        repeat (150) @(posedge clk);
        @(negedge clk);
        hold_off_cycles = 300;
        wait (pending_ops.size() < 200);
        @(negedge clk);
        quiet_mode = 1'b1;
        wait (pending_ops.size() < 140);
        @(negedge clk);
        quiet_mode = 1'b0;

        guard = 0;
        while ((pending_ops.size() != 0 || req.valid || expected_results.size() != 0)
               && guard < 1000000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0 && guard < 1000000)
            $display("sorted_keyed_record_store: match");
        else
            $display("sorted_keyed_record_store: mismatch");
        $finish;
    end

endmodule
